/* rtl/core/ttrrs_pkg.sv */
// Shared command codes and controller/datapath interface types for the task scheduler.
package ttrrs_pkg;

  typedef enum logic [3:0] {
    CMD_CREATE  = 4'd0,
    CMD_KILL    = 4'd1,
    CMD_TICK    = 4'd2,
    CMD_QUERY   = 4'd3,
    CMD_GET_UID = 4'd4,
    CMD_GET_GID = 4'd5,
    CMD_SET_UID = 4'd6,
    CMD_SET_GID = 4'd7,
    CMD_COUNT   = 4'd8,
    CMD_ID_POS  = 4'd9
  } command_t;

  localparam logic [1:0] OUTCOME_YIELD = 2'd1;

  typedef struct packed {
    logic load;
    logic scan;
    logic fetch;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

/* rtl/core/task_table_round_robin_scheduler.sv */
// Top level of the round-robin task table scheduler.
//
//  channel   handshake           payload
//  command   start / busy        command, task_id, id_value, position, run_outcome
//  result    done (one cycle)    success, result_id, result_value, task_state
//
// Done is registered and rises as the controller leaves FETCH for REPLY; FETCH follows
// the scan, which ends on the slot read that hits or on the last of SLOT_COUNT reads.
// The scan reads one slot per cycle from the id memory and stops at the first hit.
// Reset clears all live bits, the id counter to one and the scan start to slot zero.
// Busy drops as done ends, so a new transaction is accepted only after the reply;
// done pulses for one cycle and the receiver cannot stall it.
module task_table_round_robin_scheduler
  import ttrrs_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command,
  input  logic [31:0] task_id,
  input  logic [31:0] id_value,
  input  logic [7:0]  position,
  input  logic [1:0]  run_outcome,
  output logic        done,
  output logic        success,
  output logic [31:0] result_id,
  output logic [31:0] result_value,
  output logic        task_state
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ttrrs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  ttrrs_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .command      (command),
    .task_id      (task_id),
    .id_value     (id_value),
    .position     (position),
    .run_outcome  (run_outcome),
    .success      (success),
    .result_id    (result_id),
    .result_value (result_value),
    .task_state   (task_state)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  a_state_ok: assert property (@(posedge clk) disable iff (rst)
    (done && task_state) |-> success)
    else $error("ready state reported without success");

endmodule

/* rtl/core/ttrrs_ctrl.sv */
// Controller state machine: sequences load, slot scan, fetch/commit and reply.
module ttrrs_ctrl
  import ttrrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FETCH, ST_REPLY} state_t;

  state_t state;

  always_comb begin
    cmd.load  = (state == ST_IDLE) && start;
    cmd.scan  = (state == ST_SCAN);
    cmd.fetch = (state == ST_FETCH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
            busy  <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (status.scan_done) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_REPLY;
          done  <= 1'b1;
        end
        ST_REPLY: begin
          state <= ST_IDLE;
          done  <= 1'b0;
          busy  <= 1'b0;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/ttrrs_dpath.sv */
// Datapath: slot table, id memories, slot scan pipeline and result formatting.
module ttrrs_dpath
  import ttrrs_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic [3:0]  command,
  input  logic [31:0] task_id,
  input  logic [31:0] id_value,
  input  logic [7:0]  position,
  input  logic [1:0]  run_outcome,
  output logic        success,
  output logic [31:0] result_id,
  output logic [31:0] result_value,
  output logic        task_state
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  logic [31:0] tid_mem [SLOT_COUNT];
  logic [31:0] uid_mem [SLOT_COUNT];
  logic [31:0] gid_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] live;

  logic [3:0]  cmd_reg;
  logic [31:0] tid_reg;
  logic [31:0] val_reg;
  logic [7:0]  pos_reg;
  logic [1:0]  outcome_reg;

  logic [CW-1:0] cnt;
  logic [CW-1:0] live_seen;
  logic [AW-1:0] scan_start;
  logic [31:0]   next_id;
  logic          pv;
  logic          plast;
  logic          plive;
  logic [AW-1:0] paddr;
  logic [31:0]   rd_tid;
  logic          hit;
  logic [AW-1:0] hit_slot;
  logic [31:0]   hit_id;
  logic [31:0]   new_id;
  logic [31:0]   uid_rd;
  logic [31:0]   gid_rd;

  logic          issue;
  logic [AW:0]   sum;
  logic [AW-1:0] addr;
  logic          pmatch;
  logic [AW:0]   after_hit;

  always_comb begin
    issue = cmd.scan && (cnt < CW'(SLOT_COUNT));
    sum   = (AW+1)'(scan_start) + (AW+1)'(cnt);
    if (command_t'(cmd_reg) == CMD_TICK) begin
      if (sum >= (AW+1)'(SLOT_COUNT)) begin
        addr = AW'(sum - (AW+1)'(SLOT_COUNT));
      end else begin
        addr = AW'(sum);
      end
    end else begin
      addr = AW'(cnt);
    end
    after_hit = (AW+1)'(hit_slot) + (AW+1)'(1);
  end

  always_comb begin
    unique case (cmd_reg)
      CMD_CREATE:  pmatch = !plive;
      CMD_KILL, CMD_GET_UID, CMD_GET_GID, CMD_SET_UID, CMD_SET_GID:
                   pmatch = plive && (tid_reg != 32'd0) && (rd_tid == tid_reg);
      CMD_QUERY:   pmatch = plive && (rd_tid == tid_reg);
      CMD_TICK:    pmatch = plive;
      CMD_ID_POS:  pmatch = plive && (32'(live_seen) == 32'(pos_reg));
      default:     pmatch = 1'b0;
    endcase
    pmatch           = pmatch && pv && !hit;
    status.scan_done = pmatch || (pv && plast);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live       <= '0;
      scan_start <= '0;
      next_id    <= 32'd1;
      cnt        <= '0;
      live_seen  <= '0;
      pv         <= 1'b0;
      hit        <= 1'b0;
    end else if (cmd.load) begin
      cnt       <= '0;
      live_seen <= '0;
      pv        <= 1'b0;
      hit       <= 1'b0;
    end else if (cmd.scan) begin
      pv <= issue;
      if (issue) begin
        cnt <= cnt + CW'(1);
      end
      if (pmatch) begin
        hit <= 1'b1;
      end
      if (pv && plive && !hit) begin
        live_seen <= live_seen + CW'(1);
      end
    end else if (cmd.fetch && hit) begin
      pv <= 1'b0;
      unique case (cmd_reg)
        CMD_CREATE: begin
          live[hit_slot] <= 1'b1;
          next_id        <= next_id + 32'd1;
        end
        CMD_KILL: live[hit_slot] <= 1'b0;
        CMD_TICK: begin
          if (outcome_reg != OUTCOME_YIELD) begin
            live[hit_slot] <= 1'b0;
          end
          scan_start <= (after_hit >= (AW+1)'(SLOT_COUNT)) ? '0 : AW'(after_hit);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_reg     <= command;
      tid_reg     <= task_id;
      val_reg     <= id_value;
      pos_reg     <= position;
      outcome_reg <= run_outcome;
    end
    if (issue) begin
      rd_tid <= tid_mem[addr];
      plive  <= live[addr];
      paddr  <= addr;
      plast  <= (cnt == CW'(SLOT_COUNT - 1));
    end
    if (pmatch) begin
      hit_slot <= paddr;
      hit_id   <= rd_tid;
    end
    if (cmd.fetch) begin
      uid_rd <= uid_mem[hit_slot];
      gid_rd <= gid_mem[hit_slot];
      new_id <= next_id;
      if (hit) begin
        if (command_t'(cmd_reg) == CMD_CREATE) begin
          tid_mem[hit_slot] <= next_id;
          uid_mem[hit_slot] <= 32'd0;
          gid_mem[hit_slot] <= 32'd0;
        end
        if (command_t'(cmd_reg) == CMD_SET_UID) begin
          uid_mem[hit_slot] <= val_reg;
        end
        if (command_t'(cmd_reg) == CMD_SET_GID) begin
          gid_mem[hit_slot] <= val_reg;
        end
      end
    end
  end

  always_comb begin
    success      = 1'b0;
    result_id    = 32'd0;
    result_value = 32'd0;
    task_state   = 1'b0;
    unique case (cmd_reg)
      CMD_CREATE: begin
        success   = hit;
        result_id = hit ? new_id : 32'd0;
      end
      CMD_KILL, CMD_SET_UID, CMD_SET_GID: success = hit;
      CMD_TICK, CMD_ID_POS: begin
        success   = hit;
        result_id = hit ? hit_id : 32'd0;
      end
      CMD_QUERY: begin
        success    = hit;
        task_state = hit;
      end
      CMD_GET_UID: begin
        success      = hit;
        result_value = hit ? uid_rd : 32'd0;
      end
      CMD_GET_GID: begin
        success      = hit;
        result_value = hit ? gid_rd : 32'd0;
      end
      CMD_COUNT: begin
        success      = 1'b1;
        result_value = 32'(live_seen);
      end
      default: ;
    endcase
  end

endmodule

/* tb/task_table_round_robin_scheduler_test.sv */
// Testbench for the round-robin task table scheduler: directed and random commands, scoreboard check.
`timescale 1ns / 100ps

module task_table_round_robin_scheduler_test;
  import ttrrs_pkg::*;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic        success;
    logic [31:0] result_id;
    logic [31:0] result_value;
    logic        task_state;
  } sched_result_t;

  class sched_scoreboard;
    bit          live[SLOTS];
    logic [31:0] tid[SLOTS];
    logic [31:0] uid[SLOTS];
    logic [31:0] gid[SLOTS];
    logic [31:0] next_id;
    int          scan_ptr;
    sched_result_t pending[$];
    int          errors;
    int          checked;

    function new();
      for (int i = 0; i < SLOTS; i++) free_slot(i);
      next_id = 1;
      scan_ptr = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void free_slot(int i);
      live[i] = 0;
      tid[i] = '0;
      uid[i] = '0;
      gid[i] = '0;
    endfunction

    function int lookup(logic [31:0] id);
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && tid[i] == id) return i;
      return -1;
    endfunction

    function int live_count();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += live[i];
      return n;
    endfunction

    function void note_command(logic [3:0] cmd, logic [31:0] id, logic [31:0] val,
                               logic [7:0] pos, logic [1:0] outcome);
      sched_result_t r;
      int s;
      int idx;
      int n;
      r.success = 0;
      r.result_id = '0;
      r.result_value = '0;
      r.task_state = 0;
      case (cmd)
        CMD_CREATE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!live[i]) begin
              live[i] = 1;
              tid[i] = next_id;
              uid[i] = '0;
              gid[i] = '0;
              r.result_id = next_id;
              next_id = next_id + 32'd1;
              r.success = 1;
              break;
            end
          end
        end
        CMD_KILL: begin
          s = (id != 0) ? lookup(id) : -1;
          if (s >= 0) begin
            free_slot(s);
            r.success = 1;
          end
        end
        CMD_TICK: begin
          idx = scan_ptr;
          for (int k = 0; k < SLOTS; k++) begin
            if (live[idx]) begin
              r.result_id = tid[idx];
              r.success = 1;
              if (outcome != OUTCOME_YIELD) free_slot(idx);
              scan_ptr = (idx + 1) % SLOTS;
              break;
            end
            idx = (idx + 1) % SLOTS;
          end
        end
        CMD_QUERY: begin
          if (lookup(id) >= 0) begin
            r.success = 1;
            r.task_state = 1;
          end
        end
        CMD_GET_UID, CMD_GET_GID, CMD_SET_UID, CMD_SET_GID: begin
          s = (id != 0) ? lookup(id) : -1;
          if (s >= 0) begin
            r.success = 1;
            case (cmd)
              CMD_GET_UID: r.result_value = uid[s];
              CMD_GET_GID: r.result_value = gid[s];
              CMD_SET_UID: uid[s] = val;
              default: gid[s] = val;
            endcase
          end
        end
        CMD_COUNT: begin
          r.result_value = live_count();
          r.success = 1;
        end
        CMD_ID_POS: begin
          n = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (live[i]) begin
              if (n == pos) begin
                r.result_id = tid[i];
                r.success = 1;
                break;
              end
              n++;
            end
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic ok, logic [31:0] rid, logic [31:0] rval, logic st);
      sched_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: success=%0d result_id=%h", ok, rid);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (ok !== e.success) begin
        $error("success: expected %0d, actual %0d", e.success, ok);
        errors++;
      end
      if (rid !== e.result_id) begin
        $error("result_id: expected %h, actual %h", e.result_id, rid);
        errors++;
      end
      if (rval !== e.result_value) begin
        $error("result_value: expected %h, actual %h", e.result_value, rval);
        errors++;
      end
      if (st !== e.task_state) begin
        $error("task_state: expected %0d, actual %0d", e.task_state, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [3:0]  command;
  logic [31:0] task_id;
  logic [31:0] id_value;
  logic [7:0]  position;
  logic [1:0]  run_outcome;
  logic        done;
  logic        success;
  logic [31:0] result_id;
  logic [31:0] result_value;
  logic        task_state;

  sched_scoreboard board;
  int idle_cycles;
  int sent;

  task_table_round_robin_scheduler #(.SLOT_COUNT(SLOTS)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .task_id(task_id), .id_value(id_value),
    .position(position), .run_outcome(run_outcome),
    .done(done), .success(success), .result_id(result_id),
    .result_value(result_value), .task_state(task_state)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done)
      board.check_result(success, result_id, result_value, task_state);
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("task_table_round_robin_scheduler_test: done, errors");
      $finish;
    end
  end

  task automatic send_command(logic [3:0] cmd, logic [31:0] id, logic [31:0] val,
                              logic [7:0] pos, logic [1:0] outcome, int gap);
    bit taken;
    if (gap > 0) begin
      @(negedge clk);
      start <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1;
    command <= cmd;
    task_id <= id;
    id_value <= val;
    position <= pos;
    run_outcome <= outcome;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        taken = 1;
        board.note_command(cmd, id, val, pos, outcome);
      end
    end
    sent++;
  endtask

  function automatic logic [31:0] pick_id();
    int s;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return '0;
      2: return board.next_id - 32'd1;
      default: begin
        s = $urandom_range(0, SLOTS - 1);
        return board.tid[s];
      end
    endcase
  endfunction

  task automatic random_command();
    logic [3:0] cmd;
    logic [1:0] outcome;
    int w;
    int gap;
    w = $urandom_range(0, 99);
    if (w < 20) cmd = CMD_CREATE;
    else if (w < 30) cmd = CMD_KILL;
    else if (w < 50) cmd = CMD_TICK;
    else if (w < 97) cmd = 4'($urandom_range(3, 9));
    else cmd = 4'($urandom_range(10, 15));
    outcome = 2'($urandom_range(0, 3));
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    send_command(cmd, pick_id(), $urandom(), 8'($urandom_range(0, 20)) |
                 (($urandom_range(0, 15) == 0) ? 8'($urandom()) : 8'd0), outcome, gap);
  endtask

  initial begin
    board = new();
    idle_cycles = 0;
    sent = 0;
    rst = 1;
    start = 0;
    command = CMD_COUNT;
    task_id = '0;
    id_value = '0;
    position = '0;
    run_outcome = '0;
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    send_command(CMD_TICK, '0, '0, '0, 2'd0, 0);
    send_command(CMD_COUNT, '0, '0, '0, 2'd0, 0);
    for (int i = 0; i < SLOTS + 1; i++)
      send_command(CMD_CREATE, '0, '0, '0, 2'd0, 0);
    send_command(CMD_SET_UID, 32'd3, 32'hFFFF_FFFF, '0, 2'd0, 1);
    send_command(CMD_SET_GID, 32'd3, 32'hFFFF_FFFF, '0, 2'd0, 0);
    send_command(CMD_GET_UID, 32'd3, '0, '0, 2'd0, 0);
    send_command(CMD_GET_GID, 32'd3, '0, '0, 2'd0, 0);
    send_command(CMD_GET_UID, 32'd0, '0, '0, 2'd0, 0);
    send_command(CMD_QUERY, 32'hFFFF_FFFF, '0, '0, 2'd0, 0);
    send_command(CMD_ID_POS, '0, '0, 8'd15, 2'd0, 0);
    send_command(CMD_ID_POS, '0, '0, 8'd255, 2'd0, 0);
    send_command(CMD_KILL, 32'd0, '0, '0, 2'd0, 0);
    send_command(CMD_KILL, 32'd5, '0, '0, 2'd0, 0);
    send_command(CMD_TICK, '0, '0, '0, OUTCOME_YIELD, 0);
    send_command(CMD_TICK, '0, '0, '0, 2'd2, 0);
    send_command(CMD_TICK, '0, '0, '0, 2'd3, 0);
    send_command(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 2'd3, 0);

    repeat (540) random_command();

    // Drain the table, then cycle creates, queries, position lookups and ticks.
    repeat (SLOTS) send_command(CMD_TICK, '0, '0, '0, 2'd0, 0);
    repeat (40) begin
      send_command(CMD_CREATE, '0, '0, '0, 2'd0, $urandom_range(0, 17));
      send_command(CMD_QUERY, 32'd0, '0, '0, 2'd0, 0);
      send_command(CMD_ID_POS, '0, '0, 8'd0, 2'd0, 0);
      send_command(CMD_TICK, '0, '0, '0, 2'($urandom_range(0, 3)), 0);
    end

    @(negedge clk);
    start <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (SLOTS + 8) @(negedge clk);
    $display("covered %0d commands, %0d results checked, ids issued up to %h",
             sent, board.checked, board.next_id);
    if (board.errors == 0)
      $display("task_table_round_robin_scheduler_test: done, clean");
    else
      $display("task_table_round_robin_scheduler_test: done, errors");
    $finish;
  end

endmodule

/* files.f */
rtl/core/ttrrs_pkg.sv
rtl/core/ttrrs_ctrl.sv
rtl/core/ttrrs_dpath.sv
rtl/core/task_table_round_robin_scheduler.sv
tb/task_table_round_robin_scheduler_test.sv
